// ----- design/emot_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// emot_pkg
// Shared types, widths and codes of the extent map offset translator.
// ----------------------------------------------------------------------------
package emot_pkg;

	localparam int MAX_EXTENTS = 16;
	localparam int IDX_W       = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
	localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);

	localparam int BLK_W  = 16;
	localparam int BSZ_W  = 21;
	localparam int OFF_W  = 32;
	localparam int PROD_W = BLK_W + BSZ_W;

	localparam logic [BSZ_W-1:0] BSZ_RESET = BSZ_W'(512);

	localparam logic [1:0] REQ_CLEAR   = 2'd0;
	localparam logic [1:0] REQ_APPEND  = 2'd1;
	localparam logic [1:0] REQ_CHECKED = 2'd2;
	localparam logic [1:0] REQ_XLATE   = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_CONT  = 2'd2;
	localparam logic [1:0] STAT_RANGE = 2'd3;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [BLK_W-1:0] extent_start;
		logic [BLK_W-1:0] extent_count;
		logic [BLK_W-1:0] expected_start;
		logic [OFF_W-1:0] byte_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [OFF_W-1:0] area_offset;
		logic [BLK_W-1:0] blocks_total;
	} rsp_t;

	typedef struct packed {
		logic [BLK_W-1:0] start;
		logic [BLK_W-1:0] count;
	} ext_t;

	typedef struct packed {
		logic             en;
		logic [BLK_W-1:0] a;
	} mul_req_t;

endpackage
`default_nettype wire

// ----- design/emot_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// emot_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module emot_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- design/emot_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// emot_mul
// Shared registered multiplier: block count or start times block size.
// ----------------------------------------------------------------------------
module emot_mul
	import emot_pkg::*;
(
	input  wire logic              clk,
	input  wire mul_req_t          mreq,
	input  wire logic [BSZ_W-1:0]  bsz,
	output logic      [PROD_W-1:0] prod
);

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (mreq.en) begin
			prod_q <= PROD_W'(mreq.a) * PROD_W'(bsz);
		end
	end

	assign prod = prod_q;

endmodule
`default_nettype wire

// ----- design/emot_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// emot_ctrl
// Request sequencer: list update, extent walk and result register.
// ----------------------------------------------------------------------------
module emot_ctrl
	import emot_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire req_t              req,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output rsp_t                   rsp,
	output logic                   ram_we,
	output logic      [IDX_W-1:0]  ram_waddr,
	output ext_t                   ram_wdata,
	output logic      [IDX_W-1:0]  ram_raddr,
	input  wire ext_t              ram_rdata,
	output mul_req_t               mreq,
	input  wire logic [PROD_W-1:0] prod
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_MULC,
		S_CMP,
		S_MULS,
		S_ADD,
		S_OUT
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  used_q;
	logic [BLK_W-1:0]  running_q;
	logic [IDX_W-1:0]  idx_q;
	logic [OFF_W-1:0]  off_q;
	logic [BLK_W-1:0]  start_q;
	logic [1:0]        status_q;
	logic [OFF_W-1:0]  result_q;

	logic              req_xfer;
	logic              is_append;
	logic [1:0]        app_status;
	logic              hit;
	logic              last;

	assign req_xfer  = req_valid && !req_stall;
	assign is_append = (req.req_type == REQ_APPEND) || (req.req_type == REQ_CHECKED);

	always_comb begin
		if ((req.req_type == REQ_CHECKED) && (req.expected_start != running_q)) begin
			app_status = STAT_CONT;
		end else if (used_q >= CNT_W'(MAX_EXTENTS)) begin
			app_status = STAT_FULL;
		end else begin
			app_status = STAT_OK;
		end
	end

	assign ram_we          = (state_q == S_IDLE) && req_xfer && is_append &&
	                         (app_status == STAT_OK);
	assign ram_waddr       = used_q[IDX_W-1:0];
	assign ram_wdata.start = req.extent_start;
	assign ram_wdata.count = req.extent_count;
	assign ram_raddr       = idx_q;

	always_comb begin
		mreq.en = 1'b0;
		mreq.a  = ram_rdata.count;
		if (state_q == S_MULC) begin
			mreq.en = 1'b1;
		end else if (state_q == S_MULS) begin
			mreq.en = 1'b1;
			mreq.a  = start_q;
		end
	end

	assign hit  = PROD_W'(off_q) < prod;
	assign last = (CNT_W'(idx_q) + CNT_W'(1)) >= used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			used_q    <= '0;
			running_q <= '0;
			idx_q     <= '0;
			off_q     <= '0;
			start_q   <= '0;
			status_q  <= STAT_OK;
			result_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						result_q <= '0;
						idx_q    <= '0;
						off_q    <= req.byte_offset;
						state_q  <= S_OUT;
						unique case (req.req_type)
							REQ_CLEAR: begin
								used_q    <= '0;
								running_q <= '0;
								status_q  <= STAT_OK;
							end
							REQ_APPEND, REQ_CHECKED: begin
								status_q <= app_status;
								if (app_status == STAT_OK) begin
									used_q    <= used_q + CNT_W'(1);
									running_q <= running_q + req.extent_count;
								end
							end
							REQ_XLATE: begin
								if (used_q == '0) begin
									status_q <= STAT_RANGE;
								end else begin
									status_q <= STAT_OK;
									state_q  <= S_READ;
								end
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_MULC;
				end
				S_MULC: begin
					start_q <= ram_rdata.start;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (hit) begin
						state_q <= S_MULS;
					end else if (last) begin
						status_q <= STAT_RANGE;
						state_q  <= S_OUT;
					end else begin
						off_q   <= off_q - prod[OFF_W-1:0];
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_READ;
					end
				end
				S_MULS: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					result_q <= prod[OFF_W-1:0] + off_q;
					state_q  <= S_OUT;
				end
				S_OUT: begin
					if (!rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall         = (state_q != S_IDLE);
	assign rsp_valid         = (state_q == S_OUT);
	assign rsp.status        = status_q;
	assign rsp.area_offset   = result_q;
	assign rsp.blocks_total  = running_q;

endmodule
`default_nettype wire

// ----- design/extent_map_offset_translator_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// extent_map_offset_translator_top
// Extent list with file offset to allocation-area offset translation.
//
// Request channel (req_valid / req_stall / req) takes one request per
// transfer: clear, append, checked append or translate. Each request gives
// exactly one response on the response channel (rsp_valid / rsp_stall / rsp).
// Clear and append answer in the cycle after the request transfer. A translate
// of an empty list answers in the cycle after as well; otherwise the walk
// visits extents in turn, each with a RAM read, a count multiply and a compare
// and subtract, and a hit adds a start multiply, an add and the result register.
// The single extent RAM port and the shared 16 x 21 multiplier pace the walk.
// One request is in flight at a time: req_stall stays high from the request
// transfer until the response transfer. A stalled response holds its value.
// The block size register is written over cfg_valid / cfg_ready / cfg_data
// and is always ready.
// Reset empties the list, zeroes the block total and sets the block size to
// 512; extent RAM contents are not cleared.
// ----------------------------------------------------------------------------
module extent_map_offset_translator_top
	import emot_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire req_t             req,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output rsp_t                  rsp,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [BSZ_W-1:0] cfg_data
);

	logic [BSZ_W-1:0]  bsz_q;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	ext_t              ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	ext_t              ram_rdata;
	mul_req_t          mreq;
	logic [PROD_W-1:0] prod;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsz_q <= BSZ_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bsz_q <= cfg_data;
		end
	end

	emot_ram #(
		.WIDTH ($bits(ext_t)),
		.DEPTH (MAX_EXTENTS),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	emot_mul u_mul (
		.clk  (clk),
		.mreq (mreq),
		.bsz  (bsz_q),
		.prod (prod)
	);

	emot_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.mreq      (mreq),
		.prod      (prod)
	);

endmodule
`default_nettype wire

// ----- design/emot_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// emot_checker
// Port-level checks of the translator top, attached by bind.
// ----------------------------------------------------------------------------
module emot_checker
	import emot_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while a request is in flight");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall)
		else $error("request channel open while a response is pending");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != STAT_OK) |-> rsp.area_offset == '0)
		else $error("error response with nonzero offset");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req.req_type == REQ_CLEAR) |=>
		rsp_valid && (rsp.status == STAT_OK) && (rsp.blocks_total == '0))
		else $error("clear did not answer with an empty total");

endmodule

bind extent_map_offset_translator_top emot_checker u_emot_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
`default_nettype wire
